FILE: sv/ttw_pkg.sv
`default_nettype none

package ttw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths on the channels
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + COLOR_W;

    // Internal widths derived from the geometry
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CUR_W  = $clog2(CELLS + 1);
    localparam int NL_W   = $clog2(CELLS + COLUMNS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    // Blank cell: space on light gray
    localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
    localparam logic [COLOR_W-1:0] BLANK_COLOR = 8'h07;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT     = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_READ    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } t_state;

    // Memory write data / address source
    typedef enum logic [1:0] {
        WS_CURSOR,
        WS_COPY,
        WS_BLANK
    } t_wsel;

    // Memory read address source
    typedef enum logic {
        RS_INDEX,
        RS_COPY
    } t_rsel;

    typedef struct packed {
        logic  item_load;
        logic  mem_we;
        t_wsel wsel;
        logic  rd_en;
        t_rsel rsel;
        logic  cnt_clr;
        logic  cnt_inc;
        logic  cur_put;
        logic  cur_nl;
        logic  cur_scroll;
        logic  cur_clr;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  cur_end;
        logic  nl_wrap;
        logic  cnt_zero;
        logic  copy_last;
        logic  fill_last;
        logic  out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: sv/ttw_if.sv
`default_nettype none

// Command channel into the terminal
interface ttw_in_if;
    import ttw_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  color;
    logic [INDEX_W-1:0]  cell_index;

    modport source (output valid, output kind, output char_code, output color,
                    output cell_index, input ready);
    modport sink   (input valid, input kind, input char_code, input color,
                    input cell_index, output ready);
endinterface

// Response channel out of the terminal
interface ttw_out_if;
    import ttw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOR_W-1:0]  cell_color;

    modport source (output valid, output cursor_pos, output cell_char,
                    output cell_color, input ready);
    modport sink   (input valid, input cursor_pos, input cell_char,
                    input cell_color, output ready);
endinterface

`default_nettype wire

FILE: sv/ttw_ctrl.sv
`default_nettype none

module ttw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ttw_pkg::t_dp_sts i_sts,
    output ttw_pkg::t_dp_cmd o_cmd
);
    import ttw_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    // Take a new transaction when idle, or when the finished one leaves
    assign o_in_ready = (r_state == ST_IDLE) || (r_state == ST_DONE && i_sts.out_free);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (i_sts.kind)
                    KIND_PUT:     n_state = i_sts.cur_end ? ST_COPY : ST_DONE;
                    KIND_NEWLINE: n_state = i_sts.nl_wrap ? ST_COPY : ST_DONE;
                    KIND_CLEAR:   n_state = ST_CLEAR;
                    KIND_READ:    n_state = ST_DONE;
                    default:      n_state = ST_DONE;
                endcase
            end
            ST_COPY: begin
                if (i_sts.copy_last) n_state = ST_FILL;
            end
            ST_FILL: begin
                // a put still has its character to write after the scroll
                if (i_sts.fill_last) begin
                    n_state = (i_sts.kind == KIND_PUT) ? ST_EXEC : ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (i_sts.fill_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) n_state = accept ? ST_EXEC : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.wsel      = WS_CURSOR;
        o_cmd.rsel      = RS_INDEX;
        o_cmd.item_load = accept;
        unique case (r_state)
            ST_IDLE: ;
            ST_EXEC: begin
                unique case (i_sts.kind)
                    KIND_PUT: begin
                        if (i_sts.cur_end) begin
                            o_cmd.cnt_clr = 1'b1;
                        end else begin
                            o_cmd.mem_we  = 1'b1;
                            o_cmd.wsel    = WS_CURSOR;
                            o_cmd.cur_put = 1'b1;
                        end
                    end
                    KIND_NEWLINE: begin
                        o_cmd.cur_nl  = 1'b1;
                        o_cmd.cnt_clr = i_sts.nl_wrap;
                    end
                    KIND_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                    end
                    KIND_READ: begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rsel  = RS_INDEX;
                    end
                    default: ;
                endcase
            end
            ST_COPY: begin
                // read one row ahead, write the previous read one cell back
                o_cmd.rd_en   = !i_sts.copy_last;
                o_cmd.rsel    = RS_COPY;
                o_cmd.mem_we  = !i_sts.cnt_zero;
                o_cmd.wsel    = WS_COPY;
                o_cmd.cnt_inc = !i_sts.copy_last;
            end
            ST_FILL: begin
                o_cmd.mem_we     = 1'b1;
                o_cmd.wsel       = WS_BLANK;
                o_cmd.cnt_inc    = 1'b1;
                o_cmd.cur_scroll = i_sts.fill_last && (i_sts.kind == KIND_PUT);
            end
            ST_CLEAR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.wsel    = WS_BLANK;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.cur_clr = i_sts.fill_last;
            end
            ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/ttw_datapath.sv
`default_nettype none

module ttw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttw_pkg::t_dp_cmd              i_cmd,
    output ttw_pkg::t_dp_sts              o_sts,
    input  logic [ttw_pkg::KIND_W-1:0]    i_kind,
    input  logic [ttw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [ttw_pkg::COLOR_W-1:0]   i_color,
    input  logic [ttw_pkg::INDEX_W-1:0]   i_cell_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ttw_pkg::CURSOR_W-1:0]  o_cursor_pos,
    output logic [ttw_pkg::CHAR_W-1:0]    o_cell_char,
    output logic [ttw_pkg::COLOR_W-1:0]   o_cell_color
);
    import ttw_pkg::*;

    // Held transaction
    t_kind               r_kind;
    logic [CHAR_W-1:0]   r_char;
    logic [COLOR_W-1:0]  r_color;
    logic [INDEX_W-1:0]  r_index;

    // Cursor and its column
    logic [CUR_W-1:0]    r_cursor, n_cursor;
    logic [COL_W-1:0]    r_col, n_col;
    logic [NL_W-1:0]     nl_sum;
    logic [CUR_W-1:0]    row_start;
    logic                nl_wrap;

    // Sweep counter
    logic [ADDR_W-1:0]   r_cnt, n_cnt;

    // Screen memory
    logic [CELL_W-1:0]   r_mem [CELLS];
    logic [CELL_W-1:0]   r_rd_data;
    logic                r_rd_ok;
    logic                index_ok;
    logic                rd_fire;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CELL_W-1:0]   wr_data;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [CURSOR_W-1:0] r_out_cursor;
    logic [CHAR_W-1:0]   r_out_char;
    logic [COLOR_W-1:0]  r_out_color;
    logic                out_free;

    // Transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_kind  <= t_kind'(i_kind);
            r_char  <= i_char_code;
            r_color <= i_color;
            r_index <= i_cell_index;
        end
    end

    // Cursor arithmetic
    assign nl_sum    = NL_W'(r_cursor) + NL_W'(COLUMNS) - NL_W'(r_col);
    assign nl_wrap   = nl_sum >= NL_W'(CELLS);
    assign row_start = r_cursor - CUR_W'(r_col);

    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        priority if (i_cmd.cur_clr) begin
            n_cursor = '0;
            n_col    = '0;
        end else if (i_cmd.cur_put) begin
            n_cursor = r_cursor + CUR_W'(1);
            n_col    = (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + COL_W'(1);
        end else if (i_cmd.cur_nl) begin
            // a wrapping newline lands one row lower after the scroll
            n_cursor = nl_wrap ? row_start : CUR_W'(nl_sum);
            n_col    = '0;
        end else if (i_cmd.cur_scroll) begin
            n_cursor = r_cursor - CUR_W'(COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
        end
    end

    // Sweep counter for scroll and clear
    always_comb begin
        n_cnt = r_cnt;
        priority if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Memory addressing
    assign index_ok = 32'(r_index) < 32'(CELLS);
    assign rd_addr  = (i_cmd.rsel == RS_INDEX) ? ADDR_W'(r_index)
                                               : r_cnt + ADDR_W'(COLUMNS);
    assign rd_fire  = i_cmd.rd_en && ((i_cmd.rsel == RS_COPY) || index_ok);

    always_comb begin
        unique case (i_cmd.wsel)
            WS_CURSOR: begin
                wr_addr = ADDR_W'(r_cursor);
                wr_data = {r_color, r_char};
            end
            WS_COPY: begin
                wr_addr = r_cnt - ADDR_W'(1);
                wr_data = r_rd_data;
            end
            WS_BLANK: begin
                wr_addr = r_cnt;
                wr_data = {BLANK_COLOR, BLANK_CHAR};
            end
            default: begin
                wr_addr = r_cnt;
                wr_data = {BLANK_COLOR, BLANK_CHAR};
            end
        endcase
    end

    // Screen memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_fire) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.rd_en && (i_cmd.rsel == RS_INDEX)) begin
            r_rd_ok <= index_ok;
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cursor <= CURSOR_W'(r_cursor);
            if (r_kind == KIND_READ && r_rd_ok) begin
                r_out_char  <= r_rd_data[CHAR_W-1:0];
                r_out_color <= r_rd_data[CELL_W-1:CHAR_W];
            end else begin
                r_out_char  <= '0;
                r_out_color <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_cursor;
    assign o_cell_char  = r_out_char;
    assign o_cell_color = r_out_color;

    // Status to the controller
    assign o_sts.kind      = r_kind;
    assign o_sts.cur_end   = r_cursor >= CUR_W'(CELLS);
    assign o_sts.nl_wrap   = nl_wrap;
    assign o_sts.cnt_zero  = r_cnt == '0;
    assign o_sts.copy_last = r_cnt == ADDR_W'(CELLS - COLUMNS);
    assign o_sts.fill_last = r_cnt == ADDR_W'(CELLS - 1);
    assign o_sts.out_free  = out_free;

endmodule

`default_nettype wire

FILE: sv/text_terminal_writer_core.sv
// Channel   Dir  Payload                                   Transaction at
// i_cmd     in   kind, char_code, color, cell_index        valid & ready
// o_rsp     out  cursor_pos, cell_char, cell_color         valid & ready
//
// Put, newline and read pass through execute and respond; the single write
// port of the screen memory sets the sweeps. A scroll adds a copy sweep and
// a fill sweep to a newline or a put; a clear blanks every cell in a sweep.
// Reset clears the cursor and control; screen contents are undefined until
// written. A waiting response lets one more command in, which then holds in
// its respond step until the response leaves.
`default_nettype none

module text_terminal_writer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttw_in_if.sink    i_cmd,
    ttw_out_if.source o_rsp
);
    import ttw_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ttw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    ttw_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_kind       (i_cmd.kind),
        .i_char_code  (i_cmd.char_code),
        .i_color      (i_cmd.color),
        .i_cell_index (i_cmd.cell_index),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_cursor_pos (o_rsp.cursor_pos),
        .o_cell_char  (o_rsp.cell_char),
        .o_cell_color (o_rsp.cell_color)
    );

endmodule

`default_nettype wire

FILE: sv/ttw_checker.sv
`default_nettype none

module ttw_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [ttw_pkg::CURSOR_W-1:0] i_cursor_pos,
    input  logic [ttw_pkg::CHAR_W-1:0]   i_cell_char,
    input  logic [ttw_pkg::COLOR_W-1:0]  i_cell_color
);
    import ttw_pkg::*;

    logic [1:0] r_pend, n_pend;
    logic       in_acc;
    logic       out_acc;

    // Transactions taken in but not yet answered
    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_pend = r_pend;
        if (in_acc && !out_acc) begin
            n_pend = r_pend + 2'd1;
        end else if (out_acc && !in_acc) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // Stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_cursor_pos, i_cell_char, i_cell_color}))
        else $error("response changed while stalled");

    // No response without a command behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("response without outstanding command");

    // At most one in work and one waiting
    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many outstanding commands");

    // Cursor never beyond one past the last cell
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cursor_pos <= CURSOR_W'(CELLS))
        else $error("cursor out of range");

    // Reset empties the response register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

endmodule

bind text_terminal_writer_core ttw_checker u_ttw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_cursor_pos (o_rsp.cursor_pos),
    .i_cell_char  (o_rsp.cell_char),
    .i_cell_color (o_rsp.cell_color)
);

`default_nettype wire
